[rtl/nbtp_pkg.sv]
// Shared types and constants of the nested block time profiler.
// Used by nbtp_alu, nbtp_tbl and nested_block_time_profiler_core; no dependencies.
`timescale 1ns / 1ps

package nbtp_pkg;

  // Event opcodes.
  localparam logic [1:0] OP_BEGIN = 2'd0;
  localparam logic [1:0] OP_END   = 2'd1;
  localparam logic [1:0] OP_ADD   = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BAD_ID = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  // One row of per-block counters.
  typedef struct packed {
    logic [63:0] iter;
    logic [63:0] excl;
    logic [63:0] incl;
    logic [63:0] bytes;
  } row_t;

  // Requests from the sequencer to the counter and stamp memories.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic stamp_we;
  } tbl_req_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  // Which row the sequencer is working on.
  typedef enum logic [2:0] {
    PH_BEGIN_PARENT,
    PH_BEGIN_CHILD,
    PH_END_CHILD,
    PH_END_PARENT,
    PH_ADD_BYTES
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_LOAD,
    S_EXCL,
    S_INCL,
    S_ITER,
    S_BYTES,
    S_WR,
    S_POP,
    S_REP_RD,
    S_OUT
  } state_t;

endpackage

[rtl/nbtp_alu.sv]
// Shared 64-bit add/subtract unit of the profiler sequencer.
// Depends on nbtp_pkg for the operation type.
`timescale 1ns / 1ps

module nbtp_alu (
  input  nbtp_pkg::alu_op_t op,
  input  logic [63:0]       a,
  input  logic [63:0]       b,
  output logic [63:0]       y
);
  import nbtp_pkg::*;

  logic [63:0] b_eff;
  logic        cin;

  // Subtraction is a plus the complement of b plus one; wraps modulo 2^64.
  always_comb begin
    unique case (op)
      ALU_SUB: begin
        b_eff = ~b;
        cin   = 1'b1;
      end
      default: begin
        b_eff = b;
        cin   = 1'b0;
      end
    endcase
  end

  assign y = a + b_eff + {63'd0, cin};

endmodule

[rtl/nbtp_tbl.sv]
// Per-block counter memory with reset-cleared valid bits, plus the resume stamp memory.
// Depends on nbtp_pkg for the row and request types.
`timescale 1ns / 1ps

module nbtp_tbl #(
  parameter int NUM_BLOCKS = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  nbtp_pkg::tbl_req_t              req,
  input  logic [$clog2(NUM_BLOCKS)-1:0]   rd_addr,
  input  logic [$clog2(NUM_BLOCKS)-1:0]   wr_addr,
  input  nbtp_pkg::row_t                  wr_row,
  input  logic [63:0]                     wr_stamp,
  output nbtp_pkg::row_t                  rd_row,
  output logic [63:0]                     rd_stamp
);
  import nbtp_pkg::*;

  row_t                  row_mem [NUM_BLOCKS];
  logic [63:0]           stamp_mem [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] valid_r;
  row_t                  rd_row_r;
  logic [63:0]           rd_stamp_r;
  logic                  rd_vld_r;

  // Rows never written since reset read as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      row_mem[wr_addr] <= wr_row;
    end
    if (req.stamp_we) begin
      stamp_mem[wr_addr] <= wr_stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_row_r   <= row_mem[rd_addr];
      rd_stamp_r <= stamp_mem[rd_addr];
      rd_vld_r   <= valid_r[rd_addr];
    end
  end

  assign rd_row   = rd_vld_r ? rd_row_r : '0;
  assign rd_stamp = rd_stamp_r;

endmodule

[rtl/nested_block_time_profiler_core.sv]
// Nested block time profiler: one result transaction per input transaction, one event at a time.
// Errors go straight to the result stage; a read only re-reads the row, while add-bytes, begin
// and end first read, update and write back counters. One shared 64-bit adder does every update,
// one step a cycle. A new event is taken the cycle after the previous result is registered, so a
// stalled result holds off the next event.
// Synchronous active-low reset clears the stack count and the counter valid bits at once.
// Depends on nbtp_pkg, nbtp_alu and nbtp_tbl.
`timescale 1ns / 1ps

module nested_block_time_profiler_core #(
  parameter int NUM_BLOCKS  = 64,
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_block_id,
  input  logic [63:0] in_timestamp,
  input  logic [63:0] in_byte_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [7:0]  out_entry_id,
  output logic [63:0] out_iteration_count,
  output logic [63:0] out_exclusive_time,
  output logic [63:0] out_inclusive_time,
  output logic [63:0] out_byte_total,
  output logic [4:0]  out_nesting_depth
);
  import nbtp_pkg::*;

  localparam int IDX_W = $clog2(NUM_BLOCKS);
  localparam int SP_W  = $clog2(STACK_DEPTH);
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam logic [8:0]       NB_LIMIT = 9'(NUM_BLOCKS);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STACK_DEPTH);

  // Sequencer state and the event being worked on.
  state_t            state_r, state_nxt;
  phase_t            phase_r, phase_nxt;
  logic [IDX_W-1:0]  id_r, id_nxt;
  logic [63:0]       now_r, now_nxt;
  logic [63:0]       bytes_r, bytes_nxt;
  logic [IDX_W-1:0]  tgt_r, tgt_nxt;
  logic [IDX_W-1:0]  rep_r, rep_nxt;
  logic [1:0]        status_r, status_nxt;
  row_t              row_r, row_nxt;
  logic [63:0]       span_r, span_nxt;

  // Stack of open block ids.
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  stack_r [STACK_DEPTH];
  logic              push_en;
  logic [IDX_W-1:0]  top_id;

  // Shared adder and memory interface.
  alu_op_t           alu_op;
  logic [63:0]       alu_a, alu_b, alu_y;
  tbl_req_t          req;
  logic [IDX_W-1:0]  rd_addr;
  row_t              tbl_row;
  logic [63:0]       tbl_stamp;

  // Result register.
  logic              out_valid_r;
  logic              load_out;
  logic [1:0]        out_status_r;
  logic [7:0]        out_entry_id_r;
  row_t              out_row_r;
  logic [4:0]        out_depth_r;
  logic [IDX_W+7:0]  rep_ext;
  logic [CNT_W+4:0]  count_ext;
  logic              id_ok;

  assign top_id  = stack_r[SP_W'(count_r - 1'b1)];
  assign id_ok   = {1'b0, in_block_id} < NB_LIMIT;
  assign rd_addr = (state_r == S_REP_RD) ? rep_r : tgt_r;

  nbtp_alu u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y)
  );

  nbtp_tbl #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_tbl (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .rd_addr  (rd_addr),
    .wr_addr  (tgt_r),
    .wr_row   (row_r),
    .wr_stamp (now_r),
    .rd_row   (tbl_row),
    .rd_stamp (tbl_stamp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    phase_r  <= phase_nxt;
    id_r     <= id_nxt;
    now_r    <= now_nxt;
    bytes_r  <= bytes_nxt;
    tgt_r    <= tgt_nxt;
    rep_r    <= rep_nxt;
    status_r <= status_nxt;
    row_r    <= row_nxt;
    span_r   <= span_nxt;
    if (push_en) begin
      stack_r[SP_W'(count_r)] <= id_r;
    end
  end

  // Sequencer. A begin with an open parent first charges the parent, then
  // updates the new block. An end charges the popped block, then credits its
  // span to the new top. Every successful event ends by re-reading the
  // reported row, so the result shows the counters after all updates, even
  // when a block is nested inside itself.
  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    id_nxt     = id_r;
    now_nxt    = now_r;
    bytes_nxt  = bytes_r;
    tgt_nxt    = tgt_r;
    rep_nxt    = rep_r;
    status_nxt = status_r;
    row_nxt    = row_r;
    span_nxt   = span_r;
    count_nxt  = count_r;
    push_en    = 1'b0;
    load_out   = 1'b0;
    req        = '0;
    alu_op     = ALU_ADD;
    alu_a      = row_r.excl;
    alu_b      = span_r;
    in_ready   = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          id_nxt     = IDX_W'(in_block_id);
          now_nxt    = in_timestamp;
          bytes_nxt  = in_byte_count;
          status_nxt = ST_OK;
          unique case (in_opcode)
            OP_BEGIN: begin
              if (!id_ok) begin
                status_nxt = ST_BAD_ID;
                state_nxt  = S_OUT;
              end else if (count_r >= FULL_CNT) begin
                status_nxt = ST_FULL;
                state_nxt  = S_OUT;
              end else if (count_r != '0) begin
                tgt_nxt   = top_id;
                phase_nxt = PH_BEGIN_PARENT;
                state_nxt = S_RD;
              end else begin
                tgt_nxt   = IDX_W'(in_block_id);
                phase_nxt = PH_BEGIN_CHILD;
                state_nxt = S_RD;
              end
            end
            OP_END: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_OUT;
              end else begin
                tgt_nxt   = top_id;
                rep_nxt   = top_id;
                phase_nxt = PH_END_CHILD;
                state_nxt = S_RD;
              end
            end
            OP_ADD: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_OUT;
              end else begin
                tgt_nxt   = top_id;
                rep_nxt   = top_id;
                phase_nxt = PH_ADD_BYTES;
                state_nxt = S_RD;
              end
            end
            OP_READ: begin
              if (!id_ok) begin
                status_nxt = ST_BAD_ID;
                state_nxt  = S_OUT;
              end else begin
                rep_nxt   = IDX_W'(in_block_id);
                state_nxt = S_REP_RD;
              end
            end
          endcase
        end
      end
      S_RD: begin
        req.rd_en = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        row_nxt = tbl_row;
        alu_op  = ALU_SUB;
        alu_a   = now_r;
        alu_b   = tbl_stamp;
        unique case (phase_r)
          PH_BEGIN_PARENT, PH_END_CHILD: begin
            span_nxt  = alu_y;
            state_nxt = S_EXCL;
          end
          PH_END_PARENT:  state_nxt = S_INCL;
          PH_BEGIN_CHILD: state_nxt = S_ITER;
          PH_ADD_BYTES:   state_nxt = S_BYTES;
          default:        state_nxt = S_IDLE;
        endcase
      end
      S_EXCL: begin
        alu_a        = row_r.excl;
        alu_b        = span_r;
        row_nxt.excl = alu_y;
        state_nxt    = S_INCL;
      end
      S_INCL: begin
        alu_a        = row_r.incl;
        alu_b        = span_r;
        row_nxt.incl = alu_y;
        state_nxt    = S_WR;
      end
      S_ITER: begin
        alu_a        = row_r.iter;
        alu_b        = 64'd1;
        row_nxt.iter = alu_y;
        state_nxt    = S_BYTES;
      end
      S_BYTES: begin
        alu_a         = row_r.bytes;
        alu_b         = bytes_r;
        row_nxt.bytes = alu_y;
        state_nxt     = S_WR;
      end
      S_WR: begin
        req.wr_en    = 1'b1;
        req.stamp_we = (phase_r == PH_BEGIN_CHILD) || (phase_r == PH_END_PARENT);
        unique case (phase_r)
          PH_BEGIN_PARENT: begin
            tgt_nxt   = id_r;
            phase_nxt = PH_BEGIN_CHILD;
            state_nxt = S_RD;
          end
          PH_BEGIN_CHILD: begin
            push_en   = 1'b1;
            count_nxt = count_r + 1'b1;
            rep_nxt   = id_r;
            state_nxt = S_REP_RD;
          end
          PH_END_CHILD: begin
            count_nxt = count_r - 1'b1;
            state_nxt = S_POP;
          end
          default: state_nxt = S_REP_RD;
        endcase
      end
      S_POP: begin
        if (count_r != '0) begin
          tgt_nxt   = top_id;
          phase_nxt = PH_END_PARENT;
          state_nxt = S_RD;
        end else begin
          state_nxt = S_REP_RD;
        end
      end
      S_REP_RD: begin
        req.rd_en = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // The result register frees the sequencer as soon as a transaction is loaded.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign rep_ext   = {8'd0, rep_r};
  assign count_ext = {5'd0, count_r};

  // Error results carry zero counters and the unchanged depth.
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r <= status_r;
      out_depth_r  <= count_ext[4:0];
      if (status_r == ST_OK) begin
        out_entry_id_r <= rep_ext[7:0];
        out_row_r      <= tbl_row;
      end else begin
        out_entry_id_r <= '0;
        out_row_r      <= '0;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_entry_id        = out_entry_id_r;
  assign out_iteration_count = out_row_r.iter;
  assign out_exclusive_time  = out_row_r.excl;
  assign out_inclusive_time  = out_row_r.incl;
  assign out_byte_total      = out_row_r.bytes;
  assign out_nesting_depth   = out_depth_r;

  // The stack never holds more than its depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("stack count exceeds stack depth");

  // Once an event is taken, the next one waits until its result is loaded.
  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second event accepted while one is in progress");

  // Each event pushes or pops at most one block.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (count_r != $past(count_r)) |->
      (count_r == $past(count_r) + 1'b1) || (count_r == $past(count_r) - 1'b1))
    else $error("stack count moved by more than one");

  // Error results report no counters.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != ST_OK) |->
      (out_entry_id_r == '0) && (out_row_r == '0))
    else $error("error result carries counter values");

endmodule
